@@ design/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on the block clock, off while in reset
`define BSED_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication on the block clock, off while in reset
`define BSED_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ design/bsed_pkg.sv @@
package bsed_pkg;

    localparam int WORK_W     = 48;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic signed [WORK_W-1:0] WORK_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [WORK_W-1:0] WORK_MIN = 48'sh8000_0000_0000;

    typedef enum logic [1:0] {
        MODE_LOAD_KNOT = 2'd0,
        MODE_LOAD_COEF = 2'd1,
        MODE_EVAL      = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPLINE_ORDER = 2'd0,
        CFG_DERIV_ORDER  = 2'd1,
        CFG_KNOT_COUNT   = 2'd2
    } t_cfg_idx;

endpackage

@@ design/bspline_eval_derivative_top.sv @@
// load beats (knot or coefficient) are written into the table and the input stays ready;
// an evaluate beat runs a binary knot search, gathers k coefficients, then works through
// k*(k-1)/2 terms in all (k = spline order), derivative terms first, then triangle terms
// a term with a nonzero gap runs the single shared radix-2 divider for a 48-bit quotient
// one evaluate at a time; input not ready until the result is in the output register
// synchronous active-low reset clears control and config (order 4, derivative 0, 8 knots)
`include "assert_macros.svh"

module bspline_eval_derivative_top #(
    parameter int MAX_KNOTS   = 64,
    parameter int MAX_ORDER   = 8,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // table_index[5:0], table_value[37:6], sample_point[69:38], zero pad
    input  logic [bsed_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]                          i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // spline_value[31:0]
    output logic [bsed_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // saturated[0]
    output logic [0:0]                          o_m_axis_tuser,
    input  logic                                i_cfg_we,
    input  logic [bsed_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bsed_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int IW  = $clog2(MAX_KNOTS);
    localparam int CW  = IW + 1;
    localparam int OW  = $clog2(MAX_ORDER + 1);
    localparam int WIW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam logic signed [47:0] VLIM = 48'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [47:0] VMIN = -VLIM - 48'sd1;
    localparam logic [5:0]  DIV_LAST = 6'd47;
    localparam logic [48:0] MAG_BIG  = 49'h1_0000_0000_0000;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_SRCH, S_SRCH_CMP, S_GATH, S_GATH_WR, S_LEVEL,
        S_STEP, S_STEP_HI, S_STEP_LO, S_DIV_INIT, S_DIV, S_DIV_END,
        S_MUL0, S_MUL1, S_MUL2, S_WRITE, S_OUT, S_RES, S_FINISH
    } t_state;

    function automatic logic [IW-1:0] wrap_idx(input logic [CW:0] v);
        logic [CW:0] t;
        t = (v >= (CW+1)'(MAX_KNOTS)) ? v - (CW+1)'(MAX_KNOTS) : v;
        return t[IW-1:0];
    endfunction

    t_state r_state;
    logic [3:0] r_k;
    logic [2:0] r_d;
    logic [6:0] r_nc;

    logic signed [31:0] r_knot_mem [MAX_KNOTS];
    logic signed [31:0] r_coef_mem [MAX_KNOTS];
    logic signed [47:0] r_work_mem [MAX_ORDER];
    logic signed [31:0] r_knot_rd, r_coef_rd;
    logic signed [47:0] r_wa, r_wb_rd;

    logic signed [31:0] r_x, r_t_hi, r_res;
    logic [CW-1:0] r_jl, r_jh;
    logic [OW-1:0] r_s, r_m, r_r;
    logic r_deriv, r_sat, r_neg, r_ovf, r_asign, r_mneg;
    logic signed [47:0] r_wbk, r_wnew;
    logic [48:0] r_ua;
    logic [47:0] r_ub;
    logic [51:0] r_num_mag;
    logic [32:0] r_den, r_rem;
    logic [47:0] r_dsh, r_quo;
    logic [5:0]  r_cnt;
    logic [63:0] r_p0, r_mid;
    logic r_out_valid, r_out_sat;
    logic [31:0] r_out_data;

    logic w_acc;
    logic [IW-1:0] w_tab_addr, w_knot_addr, w_lo_addr;
    logic [CW:0] w_hi_sum;
    logic [CW-1:0] w_nt, w_jn;
    logic w_degenerate;
    logic signed [32:0] w_gap, w_xmlo;
    logic [32:0] w_gap_mag, w_xmlo_mag;
    logic signed [48:0] w_diff;
    logic [48:0] w_diff_mag;
    logic [51:0] w_dnum;
    logic w_ovf, w_fit;
    logic [33:0] w_trial;
    logic signed [47:0] w_div_res;
    logic w_div_sat;
    logic [47:0] w_alpha_mag;
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_mp;
    logic [48:0] w_rmag;
    logic signed [49:0] w_prod_s;
    logic signed [50:0] w_tsum;
    logic signed [47:0] w_clip;
    logic w_clip_sat;
    logic w_work_we;
    logic signed [47:0] w_work_wd;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_sat;

    // address and datapath helpers
    always_comb begin
        w_tab_addr = wrap_idx((CW+1)'(i_s_axis_tdata[5:0]));
        w_nt = (int'(r_nc) > MAX_KNOTS) ? CW'(MAX_KNOTS) : CW'(r_nc);
        w_degenerate = (r_k == 4'd0) || (int'(r_k) > MAX_ORDER)
                    || (int'(w_nt) <= int'(r_k)) || ({1'b0, r_d} >= r_k);
        w_jn = CW'(({1'b0, r_jl} + {1'b0, r_jh}) >> 1);
        w_hi_sum = (CW+1)'(r_jl) + (CW+1)'(r_m) - (CW+1)'(r_s);
        w_lo_addr = IW'(r_jl - CW'(r_s));
        unique case (r_state)
            S_SRCH, S_SRCH_CMP: w_knot_addr = w_jn[IW-1:0];
            S_STEP:             w_knot_addr = wrap_idx(w_hi_sum);
            default:            w_knot_addr = w_lo_addr;
        endcase

        w_gap = $signed({r_t_hi[31], r_t_hi}) - $signed({r_knot_rd[31], r_knot_rd});
        w_gap_mag = w_gap[32] ? 33'(-w_gap) : 33'(w_gap);
        w_xmlo = $signed({r_x[31], r_x}) - $signed({r_knot_rd[31], r_knot_rd});
        w_xmlo_mag = w_xmlo[32] ? 33'(-w_xmlo) : 33'(w_xmlo);
        w_diff = $signed({r_wa[47], r_wa}) - $signed({r_wb_rd[47], r_wb_rd});
        w_diff_mag = w_diff[48] ? 49'(-w_diff) : 49'(w_diff);
        w_dnum = 52'(w_diff_mag) * 52'(r_m);

        // divider: overflow when the integer quotient reaches 2^32
        w_ovf   = {13'b0, r_num_mag} >= {r_den, 32'b0};
        w_trial = {r_rem, r_dsh[47]};
        w_fit   = w_trial >= {1'b0, r_den};
        w_div_sat = 1'b0;
        if (r_ovf) begin
            w_div_res = r_neg ? bsed_pkg::WORK_MIN : bsed_pkg::WORK_MAX;
            w_div_sat = 1'b1;
        end else if (!r_neg) begin
            w_div_res = r_quo[47] ? bsed_pkg::WORK_MAX : $signed(r_quo);
            w_div_sat = r_quo[47];
        end else if (r_quo > 48'h8000_0000_0000) begin
            w_div_res = bsed_pkg::WORK_MIN;
            w_div_sat = 1'b1;
        end else begin
            w_div_res = -$signed(r_quo);
        end
        w_alpha_mag = w_div_res[47] ? 48'(-w_div_res) : 48'(w_div_res);

        // shared 32x32 multiplier: low partial first, then the cross term
        if (r_state == S_MUL0) begin
            w_ma = r_ua[31:0];
            w_mb = r_ub[31:0];
        end else if (r_ua[48:32] != 17'd0) begin
            w_ma = {15'b0, r_ua[48:32]};
            w_mb = r_ub[31:0];
        end else begin
            w_ma = r_ua[31:0];
            w_mb = {16'b0, r_ub[47:32]};
        end
        w_mp = 64'(w_ma) * 64'(w_mb);

        w_rmag = 49'({r_mid[30:0], 16'b0}) + 49'(r_p0 >> 16);
        if (((r_ua[48:32] != 17'd0) && (r_ub[47:32] != 16'd0))
            || (r_mid >= 64'h8000_0000) || (w_rmag > MAG_BIG)) begin
            w_rmag = MAG_BIG;
        end
        w_prod_s = r_mneg ? -$signed({1'b0, w_rmag}) : $signed({1'b0, w_rmag});
        w_tsum = 51'(r_wbk) + 51'(w_prod_s);
        w_clip_sat = 1'b1;
        if (w_tsum > 51'(bsed_pkg::WORK_MAX)) begin
            w_clip = bsed_pkg::WORK_MAX;
        end else if (w_tsum < 51'(bsed_pkg::WORK_MIN)) begin
            w_clip = bsed_pkg::WORK_MIN;
        end else begin
            w_clip = w_tsum[47:0];
            w_clip_sat = 1'b0;
        end

        w_work_we = (r_state == S_GATH_WR) || (r_state == S_WRITE);
        w_work_wd = (r_state == S_GATH_WR) ? 48'(r_coef_rd) : r_wnew;
    end

    // table memories, registered read
    always_ff @(posedge i_clk) begin
        if (w_acc && (bsed_pkg::t_mode'(i_s_axis_tuser) == bsed_pkg::MODE_LOAD_KNOT)) begin
            r_knot_mem[w_tab_addr] <= $signed(i_s_axis_tdata[37:6]);
        end
        r_knot_rd <= r_knot_mem[w_knot_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && (bsed_pkg::t_mode'(i_s_axis_tuser) == bsed_pkg::MODE_LOAD_COEF)) begin
            r_coef_mem[w_tab_addr] <= $signed(i_s_axis_tdata[37:6]);
        end
        r_coef_rd <= r_coef_mem[w_lo_addr];
    end

    // de boor work vector, read at s and s+1
    always_ff @(posedge i_clk) begin
        if (w_work_we) begin
            r_work_mem[r_s[WIW-1:0]] <= w_work_wd;
        end
        r_wa    <= r_work_mem[r_s[WIW-1:0]];
        r_wb_rd <= r_work_mem[WIW'(r_s + OW'(1))];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_k         <= 4'd4;
            r_d         <= 3'd0;
            r_nc        <= 7'd8;
        end else begin
            if (i_cfg_we) begin
                unique case (bsed_pkg::t_cfg_idx'(i_cfg_index))
                    bsed_pkg::CFG_SPLINE_ORDER: r_k  <= i_cfg_data[3:0];
                    bsed_pkg::CFG_DERIV_ORDER:  r_d  <= i_cfg_data[2:0];
                    bsed_pkg::CFG_KNOT_COUNT:   r_nc <= i_cfg_data;
                    default: ;
                endcase
            end
            // a finishing result reloads the output register itself
            if (r_out_valid && i_m_axis_tready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc && (bsed_pkg::t_mode'(i_s_axis_tuser) == bsed_pkg::MODE_EVAL)) begin
                        r_x     <= $signed(i_s_axis_tdata[69:38]);
                        r_sat   <= 1'b0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_degenerate) begin
                        r_res   <= 32'd0;
                        r_state <= S_FINISH;
                    end else begin
                        r_jl    <= CW'(r_k) - CW'(1);
                        r_jh    <= w_nt - CW'(r_k);
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (r_jh > r_jl + CW'(1)) begin
                        r_state <= S_SRCH_CMP;
                    end else begin
                        r_s     <= '0;
                        r_state <= S_GATH;
                    end
                end
                S_SRCH_CMP: begin
                    // equal to a knot keeps the lower interval
                    if (r_x > r_knot_rd) begin
                        r_jl <= w_jn;
                    end else begin
                        r_jh <= w_jn;
                    end
                    r_state <= S_SRCH;
                end
                S_GATH: r_state <= S_GATH_WR;
                S_GATH_WR: begin
                    r_s <= r_s + OW'(1);
                    if (r_s + OW'(1) == OW'(r_k)) begin
                        r_m     <= OW'(r_k);
                        r_r     <= '0;
                        r_state <= S_LEVEL;
                    end else begin
                        r_state <= S_GATH;
                    end
                end
                S_LEVEL: begin
                    r_s <= '0;
                    if (int'(r_r) < int'(r_d)) begin
                        r_m     <= r_m - OW'(1);
                        r_r     <= r_r + OW'(1);
                        r_deriv <= 1'b1;
                        r_state <= S_STEP;
                    end else if (r_m > OW'(1)) begin
                        r_m     <= r_m - OW'(1);
                        r_deriv <= 1'b0;
                        r_state <= S_STEP;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_STEP: r_state <= S_STEP_HI;
                S_STEP_HI: begin
                    r_t_hi  <= r_knot_rd;
                    r_state <= S_STEP_LO;
                end
                S_STEP_LO: begin
                    r_wbk   <= r_wb_rd;
                    r_ua    <= w_diff_mag;
                    r_asign <= w_diff[48];
                    if (w_gap == 33'sd0) begin
                        // zero gap: derivative term zero, alpha zero
                        r_wnew  <= r_deriv ? 48'sd0 : r_wb_rd;
                        r_state <= S_WRITE;
                    end else begin
                        r_den     <= w_gap_mag;
                        r_neg     <= (r_deriv ? w_diff[48] : w_xmlo[32]) ^ w_gap[32];
                        r_num_mag <= r_deriv ? w_dnum : 52'(w_xmlo_mag);
                        r_state   <= S_DIV_INIT;
                    end
                end
                S_DIV_INIT: begin
                    r_ovf <= w_ovf;
                    r_rem <= 33'(r_num_mag[51:32]);
                    r_dsh <= {r_num_mag[31:0], 16'b0};
                    r_quo <= '0;
                    r_cnt <= '0;
                    r_state <= w_ovf ? S_DIV_END : S_DIV;
                end
                S_DIV: begin
                    r_rem <= w_fit ? 33'(w_trial - {1'b0, r_den}) : w_trial[32:0];
                    r_quo <= {r_quo[46:0], w_fit};
                    r_dsh <= r_dsh << 1;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_DIV_END;
                    end
                end
                S_DIV_END: begin
                    if (w_div_sat) begin
                        r_sat <= 1'b1;
                    end
                    if (r_deriv) begin
                        r_wnew  <= w_div_res;
                        r_state <= S_WRITE;
                    end else begin
                        r_ub    <= w_alpha_mag;
                        r_mneg  <= r_asign ^ w_div_res[47];
                        r_state <= S_MUL0;
                    end
                end
                S_MUL0: begin
                    r_p0    <= w_mp;
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_mid   <= w_mp;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_wnew <= w_clip;
                    if (w_clip_sat) begin
                        r_sat <= 1'b1;
                    end
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_s <= r_s + OW'(1);
                    r_state <= (r_s + OW'(1) == r_m) ? S_LEVEL : S_STEP;
                end
                S_OUT: r_state <= S_RES;
                S_RES: begin
                    if (r_wa > VLIM) begin
                        r_res <= VLIM[31:0];
                        r_sat <= 1'b1;
                    end else if (r_wa < VMIN) begin
                        r_res <= VMIN[31:0];
                        r_sat <= 1'b1;
                    end else begin
                        r_res <= r_wa[31:0];
                    end
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_out_sat   <= r_sat;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `BSED_ASSERT_IMP(a_search_bracket, r_state == S_SRCH_CMP, r_jl < r_jh)
    `BSED_ASSERT_IMP(a_work_index, (r_state == S_STEP) || (r_state == S_WRITE), r_s < r_m)
    `BSED_ASSERT_IMP(a_result_from_finish, $rose(r_out_valid), $past(r_state) == S_FINISH)
    `BSED_ASSERT_NXT(a_div_ends, (r_state == S_DIV) && (r_cnt == DIV_LAST), r_state == S_DIV_END)

endmodule

@@ verif/tb_bspline_eval_derivative_top.sv @@
module tb_bspline_eval_derivative_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TABLE_DEPTH  = 64;
    localparam int          ORDER_LIMIT  = 8;
    localparam int          LONG_HOLD    = 6000;
    localparam int          SETTLE       = 40;
    localparam longint      CYCLE_LIMIT  = 4000000;
    localparam logic [1:0]  MODE_IGNORED = 2'd3;
    localparam longint      W_MAX        = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint      W_MIN        = -W_MAX - 1;
    localparam longint      W_BIG        = 64'sh0001_0000_0000_0000;

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } t_spline_result;

    class spline_checker;
        longint         knot[TABLE_DEPTH];
        longint         coef[TABLE_DEPTH];
        longint         work[ORDER_LIMIT + 1];
        int             order_k;
        int             deriv_d;
        int             knots_n;
        t_spline_result expected_values[$];
        int             errors;

        function new();
            order_k = 4;
            deriv_d = 0;
            knots_n = 8;
            errors  = 0;
            foreach (knot[i]) begin
                knot[i] = 0;
                coef[i] = 0;
            end
        endfunction

        function void set_cfg(bsed_pkg::t_cfg_idx idx, logic [bsed_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                bsed_pkg::CFG_SPLINE_ORDER: order_k = int'(data[3:0]);
                bsed_pkg::CFG_DERIV_ORDER:  deriv_d = int'(data[2:0]);
                bsed_pkg::CFG_KNOT_COUNT:   knots_n = int'(data[6:0]);
                default: ;
            endcase
        endfunction

        function longint clip48(longint v, inout bit sat);
            if (v > W_MAX) begin
                sat = 1'b1;
                return W_MAX;
            end
            if (v < W_MIN) begin
                sat = 1'b1;
                return W_MIN;
            end
            return v;
        endfunction

        // q16 quotient with truncation toward zero
        function longint qdiv(longint num, longint den, inout bit sat);
            longint q;
            longint r;
            q = num / den;
            r = num % den;
            if (q >= (longint'(1) << 31)) begin
                sat = 1'b1;
                return W_MAX;
            end
            if (q < -(longint'(1) << 31)) begin
                sat = 1'b1;
                return W_MIN;
            end
            return clip48(q * 65536 + (r * 65536) / den, sat);
        endfunction

        // q16 product, magnitude capped at 2^48
        function longint qmul(longint a, longint b);
            bit                neg;
            longint unsigned   ua, ub, a1, a0, b1, b0, mid, r;
            neg = (a < 0) != (b < 0);
            ua  = (a < 0) ? longint'(-a) : a;
            ub  = (b < 0) ? longint'(-b) : b;
            a1  = ua >> 32;
            a0  = ua & 64'hFFFF_FFFF;
            b1  = ub >> 32;
            b0  = ub & 64'hFFFF_FFFF;
            if (a1 != 0 && b1 != 0) begin
                r = W_BIG;
            end else begin
                mid = a1 * b0 + a0 * b1;
                if (mid >= 64'h8000_0000) begin
                    r = W_BIG;
                end else begin
                    r = (mid << 16) + ((a0 * b0) >> 16);
                    if (r > W_BIG) r = W_BIG;
                end
            end
            return neg ? -longint'(r) : longint'(r);
        endfunction

        function longint eval_at(longint x, inout bit sat);
            int     k, d, nt, jl, jh, jn, m;
            longint lo, gap, alpha;
            k  = order_k;
            d  = deriv_d;
            nt = (knots_n > TABLE_DEPTH) ? TABLE_DEPTH : knots_n;
            if (k < 1 || k > ORDER_LIMIT || nt <= k || d >= k) return 0;
            jl = k - 1;
            jh = nt - k;
            while (jh > jl + 1) begin
                jn = (jl + jh) / 2;
                if (x > knot[jn % TABLE_DEPTH]) jl = jn;
                else jh = jn;
            end
            for (int s = 0; s < k; s++) work[s] = coef[(jl - s) % TABLE_DEPTH];
            m = k;
            for (int r = 0; r < d; r++) begin
                m--;
                for (int s = 0; s < m; s++) begin
                    gap = knot[(jl + m - s) % TABLE_DEPTH] - knot[(jl - s) % TABLE_DEPTH];
                    if (gap == 0) work[s] = 0;
                    else work[s] = qdiv((work[s] - work[s + 1]) * longint'(m), gap, sat);
                end
            end
            while (m > 1) begin
                m--;
                for (int s = 0; s < m; s++) begin
                    lo    = knot[(jl - s) % TABLE_DEPTH];
                    gap   = knot[(jl + m - s) % TABLE_DEPTH] - lo;
                    alpha = (gap == 0) ? 0 : qdiv(x - lo, gap, sat);
                    work[s] = clip48(work[s + 1] + qmul(work[s] - work[s + 1], alpha), sat);
                end
            end
            if (work[0] > 64'sd2147483647) begin
                sat = 1'b1;
                return 64'sd2147483647;
            end
            if (work[0] < -64'sd2147483648) begin
                sat = 1'b1;
                return -64'sd2147483648;
            end
            return work[0];
        endfunction

        function void note_input(logic [1:0] mode, logic [5:0] idx, logic [31:0] val,
                                 logic [31:0] pt);
            t_spline_result res;
            bit             sat;
            longint         v;
            sat = 1'b0;
            if (mode == bsed_pkg::MODE_LOAD_KNOT) begin
                knot[idx] = longint'(signed'(val));
            end else if (mode == bsed_pkg::MODE_LOAD_COEF) begin
                coef[idx] = longint'(signed'(val));
            end else if (mode == bsed_pkg::MODE_EVAL) begin
                v         = eval_at(longint'(signed'(pt)), sat);
                res.value = v[31:0];
                res.sat   = sat;
                expected_values.push_back(res);
            end
        endfunction

        function void check_result(logic [31:0] value, logic sat);
            t_spline_result exp_res;
            if (expected_values.size() == 0) begin
                $display("%0t: unexpected result beat value %h sat %b", $time, value, sat);
                errors++;
                return;
            end
            exp_res = expected_values.pop_front();
            if (value !== exp_res.value) begin
                $display("%0t: spline_value mismatch expected %h actual %h",
                         $time, exp_res.value, value);
                errors++;
            end
            if (sat !== exp_res.sat) begin
                $display("%0t: saturated mismatch expected %b actual %b",
                         $time, exp_res.sat, sat);
                errors++;
            end
        endfunction

        function int pending();
            return expected_values.size();
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             s_tvalid;
    logic                             o_s_axis_tready;
    logic [bsed_pkg::IN_DATA_W-1:0]   s_tdata;
    logic [1:0]                       s_tuser;
    logic                             o_m_axis_tvalid;
    logic                             m_tready;
    logic [bsed_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata;
    logic [0:0]                       o_m_axis_tuser;
    logic                             cfg_we;
    bsed_pkg::t_cfg_idx               cfg_index;
    logic [bsed_pkg::CFG_DATA_W-1:0]  cfg_data;

    spline_checker sb = new();
    bit      no_idle;
    bit      hold_req;
    int      hold_left;
    int      stall_left;
    longint  cycles;

    bspline_eval_derivative_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: short random stalls, a few long ones, and one long hold-off on request
    always @(posedge i_clk) begin
        int r;
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (no_idle) begin
            m_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                m_tready <= 1'b1;
            end else begin
                stall_left = (r < 96) ? $urandom_range(1, 4) : $urandom_range(20, 150);
                m_tready <= 1'b0;
            end
        end
    end

    // output and ready are stable mid-cycle; the beat is taken at the next edge
    always @(negedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser[0]);
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_item(input logic [1:0] mode, input logic [5:0] idx,
                             input logic [31:0] val, input logic [31:0] pt);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, pt, val, idx};
        s_tuser  <= mode;
        @(negedge i_clk);
        while (!o_s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
        sb.note_input(mode, idx, val, pt);
    endtask

    task automatic write_cfg(input bsed_pkg::t_cfg_idx idx,
                             input logic [bsed_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        sb.set_cfg(idx, data);
    endtask

    // drain everything in flight before touching the registers
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // sorted knots with the odd repeated knot, coefficients small or full range
    task automatic load_tables(input int step_bits);
        longint      cur;
        logic [31:0] c;
        cur = longint'($urandom_range(0, 2 << 20)) - (1 << 20);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            send_item(bsed_pkg::MODE_LOAD_KNOT, i[5:0], cur[31:0], $urandom);
            if ($urandom_range(0, 9) != 0) cur += $urandom_range(1, 1 << step_bits);
        end
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if ($urandom_range(0, 2) == 0) c = $urandom;
            else c = $urandom_range(0, 1 << 19) - (1 << 18);
            send_item(bsed_pkg::MODE_LOAD_COEF, i[5:0], c, $urandom);
        end
    endtask

    function automatic logic [31:0] pick_point();
        int     n, i, r;
        longint lo, hi, x;
        n = (sb.knots_n > TABLE_DEPTH) ? TABLE_DEPTH : sb.knots_n;
        if (n < 2) n = 2;
        i  = $urandom_range(0, n - 2);
        lo = sb.knot[i];
        hi = sb.knot[i + 1];
        r  = $urandom_range(0, 99);
        if (r < 45)      x = (hi > lo) ? lo + longint'($urandom) % (hi - lo + 1) : lo;
        else if (r < 65) x = sb.knot[i];
        else if (r < 75) x = sb.knot[0] - $urandom_range(0, 1 << 20);
        else if (r < 85) x = sb.knot[n - 1] + $urandom_range(0, 1 << 20);
        else             x = $urandom;
        return x[31:0];
    endfunction

    task automatic run_phase(input int k, input int d, input int kc, input int n_items,
                             input int step_bits, input bit hold_off);
        int r;
        wait_idle();
        write_cfg(bsed_pkg::CFG_SPLINE_ORDER, k[bsed_pkg::CFG_DATA_W-1:0]);
        write_cfg(bsed_pkg::CFG_DERIV_ORDER, d[bsed_pkg::CFG_DATA_W-1:0]);
        write_cfg(bsed_pkg::CFG_KNOT_COUNT, kc[bsed_pkg::CFG_DATA_W-1:0]);
        no_idle = ($urandom_range(0, 3) == 0);
        if (step_bits > 0) load_tables(step_bits);
        if (hold_off) hold_req = 1'b1;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 6)
                send_item(bsed_pkg::MODE_LOAD_KNOT, 6'($urandom), $urandom, $urandom);
            else if (r < 12)
                send_item(bsed_pkg::MODE_LOAD_COEF, 6'($urandom), $urandom, $urandom);
            else if (r < 14)
                send_item(MODE_IGNORED, 6'($urandom), $urandom, $urandom);
            else
                send_item(bsed_pkg::MODE_EVAL, 6'($urandom), $urandom, pick_point());
        end
    endtask

    initial begin
        int k, d;
        i_rst_n   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= bsed_pkg::MODE_LOAD_KNOT;
        m_tready  <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= bsed_pkg::CFG_SPLINE_ORDER;
        cfg_data  <= '0;
        no_idle    = 1'b0;
        hold_req   = 1'b0;
        hold_left  = 0;
        stall_left = 0;
        cycles     = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, at reset settings
        load_tables(16);
        send_item(bsed_pkg::MODE_LOAD_COEF, 6'd0, 32'h7FFF_FFFF, 32'h0);
        send_item(bsed_pkg::MODE_LOAD_COEF, 6'd1, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(bsed_pkg::MODE_LOAD_COEF, 6'd63, 32'hFFFF_FFFF, 32'h0);
        send_item(bsed_pkg::MODE_LOAD_KNOT, 6'd4, sb.knot[3][31:0], 32'h0);
        send_item(bsed_pkg::MODE_EVAL, 6'd0, 32'h0, sb.knot[3][31:0]);
        send_item(bsed_pkg::MODE_EVAL, 6'd63, 32'hFFFF_FFFF, sb.knot[4][31:0]);
        send_item(bsed_pkg::MODE_EVAL, 6'd0, 32'h0, sb.knot[5][31:0]);
        send_item(bsed_pkg::MODE_EVAL, 6'd0, 32'h0, 32'h7FFF_FFFF);
        send_item(bsed_pkg::MODE_EVAL, 6'd0, 32'h0, 32'h8000_0000);
        send_item(bsed_pkg::MODE_EVAL, 6'd0, 32'h0, 32'h0);
        send_item(bsed_pkg::MODE_EVAL, 6'd0, 32'h0, 32'hFFFF_FFFF);
        send_item(MODE_IGNORED, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(bsed_pkg::MODE_EVAL, 6'd0, 32'h0, sb.knot[7][31:0] + 32'h1_0000);
        send_item(bsed_pkg::MODE_EVAL, 6'd0, 32'h0, sb.knot[0][31:0] - 32'h1_0000);
        send_item(bsed_pkg::MODE_EVAL, 6'd0, 32'h0,
                  (sb.knot[5][31:0] + sb.knot[6][31:0]) >> 1);

        run_phase(4, 0, 8, 30, 0, 1'b0);
        run_phase(1, 0, 2, 30, 0, 1'b0);
        run_phase(1, 0, 64, 40, 14, 1'b0);
        run_phase(8, 7, 64, 40, 0, 1'b1);     // receiver holds off, input backs up
        run_phase(8, 0, 64, 40, 24, 1'b0);
        run_phase(8, 3, 20, 30, 0, 1'b0);
        run_phase(2, 1, 127, 50, 12, 1'b0);   // knot count beyond the table
        run_phase(3, 0, 5, 40, 0, 1'b0);      // short knot table
        run_phase(5, 5, 30, 20, 0, 1'b0);     // derivative not below order
        run_phase(0, 0, 10, 15, 0, 1'b0);
        run_phase(15, 7, 10, 15, 0, 1'b0);
        run_phase(9, 0, 64, 15, 0, 1'b0);
        run_phase(4, 2, 4, 20, 0, 1'b0);      // knot count not above order
        run_phase(3, 2, 0, 15, 0, 1'b0);
        run_phase(6, 2, 40, 40, 18, 1'b0);
        run_phase(7, 6, 64, 30, 0, 1'b0);
        for (int p = 0; p < 6; p++) begin
            k = $urandom_range(1, 6);
            d = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(0, k - 1);
            run_phase(k, d, $urandom_range(k + 1, 64), 15, 0, 1'b0);
        end

        wait_idle();
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
